### rtl/dscv_pkg.sv
// Shared constants, types, sine table and microcode program for the click voice core.
`default_nettype none

package dscv_pkg;

  // Sine table geometry and sample rate
  localparam int SINE_ADDR_BITS = 10;
  localparam int SAMPLE_RATE    = 48000;
  localparam int QUARTER        = 1 << (SINE_ADDR_BITS - 2);
  localparam int K_W            = SINE_ADDR_BITS - 1;
  localparam int Q30_BITS       = 30;

  // Field widths
  localparam int PHASE_W  = 16;
  localparam int STEP_W   = 15;
  localparam int LEN_W    = 16;
  localparam int GAIN_W   = 15;
  localparam int SMAG_W   = 15;
  localparam int ENV_W    = 16;
  localparam int QUOT_W   = 17;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int EE_W     = 2 * ENV_W;
  localparam int SG_W     = SMAG_W + GAIN_W;
  localparam int PROD_W   = EE_W + SG_W;
  localparam int PROD_SHIFT = 47;
  localparam int DIV_CNT_W = 5;
  localparam int DIV_STEPS = QUOT_W;

  // Register reset values follow the sample rate
  localparam int ACCENT_STEP_RST =
    ((1760 * 65536 + SAMPLE_RATE / 2) / SAMPLE_RATE) % 32768;
  localparam int NORMAL_STEP_RST =
    ((1120 * 65536 + SAMPLE_RATE / 2) / SAMPLE_RATE) % 32768;
  localparam int ACCENT_LEN_RST  = (28 * SAMPLE_RATE / 1000) % 65536;
  localparam int NORMAL_LEN_RST  = (20 * SAMPLE_RATE / 1000) % 65536;
  localparam int ACCENT_GAIN_RST = 11141;
  localparam int NORMAL_GAIN_RST = 7209;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCENT_STEP = 3'd0,
    REG_NORMAL_STEP = 3'd1,
    REG_ACCENT_LEN  = 3'd2,
    REG_NORMAL_LEN  = 3'd3,
    REG_ACCENT_GAIN = 3'd4,
    REG_NORMAL_GAIN = 3'd5
  } reg_idx_e;

  // Quarter-wave sine table, Q0.15 magnitude, entries 0..QUARTER
  typedef logic [SMAG_W-1:0] qsine_t [QUARTER+1];

  // Scale a Q60 product back to Q30, truncating toward zero
  function automatic longint q30_trunc(longint x);
    if (x < 0) return -((-x) >>> Q30_BITS);
    return x >>> Q30_BITS;
  endfunction

  function automatic qsine_t build_qsine();
    qsine_t tbl;
    longint q30;
    longint u;
    longint u2;
    longint p;
    longint s;
    longint m;
    q30 = 64'sd1 <<< Q30_BITS;
    for (int k = 0; k <= QUARTER; k++) begin
      u  = longint'(k) * (q30 >>> (SINE_ADDR_BITS - 2));
      u2 = q30_trunc(u * u);
      p  = 64'sd172272;
      p  = -64'sd5026995 + q30_trunc(p * u2);
      p  = 64'sd85569306 + q30_trunc(p * u2);
      p  = -64'sd693598668 + q30_trunc(p * u2);
      p  = 64'sd1686629713 + q30_trunc(p * u2);
      s  = q30_trunc(u * p);
      if (s < 0) s = 0;
      if (s > q30) s = q30;
      m = (s * 32767 + (q30 >>> 1)) >>> Q30_BITS;
      if (m > 32767) m = 32767;
      tbl[k] = SMAG_W'(m);
    end
    return tbl;
  endfunction

  localparam qsine_t QSINE = build_qsine();

  // Microcode: datapath operations
  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_LOAD     = 4'd1,
    OP_DIV_INIT = 4'd2,
    OP_DIV_STEP = 4'd3,
    OP_MUL_EE   = 4'd4,
    OP_MUL_SG   = 4'd5,
    OP_MUL_FIN  = 4'd6,
    OP_RENDER   = 4'd7,
    OP_ZERO     = 4'd8
  } uop_e;

  // Microcode: jump conditions
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NO_REQ   = 3'd2,
    C_SILENT   = 3'd3,
    C_DIV_MORE = 3'd4,
    C_OUT_BUSY = 3'd5
  } ucond_e;

  localparam int UPC_W     = 4;
  localparam int UC_DEPTH  = 12;

  typedef struct packed {
    uop_e             op;
    ucond_e           cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  // Step addresses
  localparam logic [UPC_W-1:0] UPC_FETCH  = 4'd0;
  localparam logic [UPC_W-1:0] UPC_LOAD   = 4'd1;
  localparam logic [UPC_W-1:0] UPC_CHECK  = 4'd2;
  localparam logic [UPC_W-1:0] UPC_DINIT  = 4'd3;
  localparam logic [UPC_W-1:0] UPC_DSTEP  = 4'd4;
  localparam logic [UPC_W-1:0] UPC_MEE    = 4'd5;
  localparam logic [UPC_W-1:0] UPC_MSG    = 4'd6;
  localparam logic [UPC_W-1:0] UPC_MFIN   = 4'd7;
  localparam logic [UPC_W-1:0] UPC_HOLDR  = 4'd8;
  localparam logic [UPC_W-1:0] UPC_RENDER = 4'd9;
  localparam logic [UPC_W-1:0] UPC_HOLDZ  = 4'd10;
  localparam logic [UPC_W-1:0] UPC_ZERO   = 4'd11;

  localparam uword_t UCODE [UC_DEPTH] = '{
    '{OP_NOP,      C_NO_REQ,   UPC_FETCH},
    '{OP_LOAD,     C_NEVER,    UPC_FETCH},
    '{OP_NOP,      C_SILENT,   UPC_HOLDZ},
    '{OP_DIV_INIT, C_NEVER,    UPC_FETCH},
    '{OP_DIV_STEP, C_DIV_MORE, UPC_DSTEP},
    '{OP_MUL_EE,   C_NEVER,    UPC_FETCH},
    '{OP_MUL_SG,   C_NEVER,    UPC_FETCH},
    '{OP_MUL_FIN,  C_NEVER,    UPC_FETCH},
    '{OP_NOP,      C_OUT_BUSY, UPC_HOLDR},
    '{OP_RENDER,   C_ALWAYS,   UPC_FETCH},
    '{OP_NOP,      C_OUT_BUSY, UPC_HOLDZ},
    '{OP_ZERO,     C_ALWAYS,   UPC_FETCH}
  };

endpackage

`default_nettype wire

### rtl/decaying_sine_click_voice_core.sv
// Click voice: microcoded sequencer over a shared divider step and multiplier.
// A sounding frame runs the 17-step envelope division and three passes through one
// multiplier; a silent frame skips both and outputs a zero sample. A new request is
// stalled until the sequence for the current frame returns to fetch.
// A new request is taken while the previous result still waits in the output register.
// Reset: asynchronous, active low; registers take their defaults, voice state clears.
`default_nettype none

module decaying_sine_click_voice_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dscv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dscv_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              beat_i,
  input  wire logic                              accent_i,
  input  wire logic                              running_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [dscv_pkg::SAMPLE_W-1:0]   sample_o,
  output logic                                   active_o
);
  import dscv_pkg::*;

  // Configuration registers
  logic [STEP_W-1:0] acc_step_q, nrm_step_q;
  logic [LEN_W-1:0]  acc_len_q, nrm_len_q;
  logic [GAIN_W-1:0] acc_gain_q, nrm_gain_q;

  // Voice state
  logic [PHASE_W-1:0] phase_q;
  logic [STEP_W-1:0]  step_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [LEN_W-1:0]   remain_q;
  logic [LEN_W-1:0]   total_q;

  // Request latches and datapath registers
  logic beat_q, accent_q, run_q;
  logic [QUOT_W-1:0]    rem_q, quot_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic [SMAG_W-1:0]    smag_q;
  logic                 neg_q;
  logic [EE_W-1:0]      ee_q;
  logic [SG_W-1:0]      sg_q;
  logic [PROD_W-1:0]    prod_q;

  // Sequencer and output register
  logic [UPC_W-1:0]    upc_q, upc_d;
  logic                out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                active_q;

  uword_t uw;
  logic   in_acc, out_acc, jump;

  assign uw         = UCODE[upc_q];
  assign in_stall_o = (upc_q != UPC_FETCH);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign sample_o   = sample_q;
  assign active_o   = active_q;

  // Evaluate the jump condition of the current step
  always_comb begin
    case (uw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_REQ:   jump = !in_acc;
      C_SILENT:   jump = !run_q || (remain_q == '0) || (total_q == '0);
      C_DIV_MORE: jump = (dcnt_q != DIV_CNT_W'(1));
      C_OUT_BUSY: jump = out_valid_q && out_stall_i;
      default:    jump = 1'b0;
    endcase
    upc_d = jump ? uw.target : upc_q + UPC_W'(1);
  end

  // Sine table address from the phase
  logic [SINE_ADDR_BITS-1:0] saddr;
  logic [K_W-1:0]            sk;
  assign saddr = phase_q[PHASE_W-1 -: SINE_ADDR_BITS];
  assign sk = saddr[SINE_ADDR_BITS-2]
            ? (K_W'(QUARTER) - {1'b0, saddr[SINE_ADDR_BITS-3:0]})
            : {1'b0, saddr[SINE_ADDR_BITS-3:0]};

  // Restoring divider step
  logic                ge;
  logic [QUOT_W-1:0]   diff, rsel;
  assign ge   = rem_q >= {1'b0, total_q};
  assign diff = rem_q - {1'b0, total_q};
  assign rsel = ge ? diff : rem_q;

  // Saturated envelope
  logic [ENV_W-1:0] env;
  assign env = quot_q[QUOT_W-1] ? {ENV_W{1'b1}} : quot_q[ENV_W-1:0];

  // Shared multiplier operand select
  logic [EE_W-1:0]   mul_a;
  logic [SG_W-1:0]   mul_b;
  logic [PROD_W-1:0] mul_p;
  always_comb begin
    case (uw.op)
      OP_MUL_EE: begin
        mul_a = EE_W'(env);
        mul_b = SG_W'(env);
      end
      OP_MUL_SG: begin
        mul_a = EE_W'(smag_q);
        mul_b = SG_W'(gain_q);
      end
      default: begin
        mul_a = ee_q;
        mul_b = sg_q;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Rendered sample with sign restored
  logic [SAMPLE_W-1:0] mag16;
  assign mag16 = {1'b0, prod_q[PROD_SHIFT +: SMAG_W]};

  // Advance sequencer and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UPC_FETCH;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (uw.op == OP_RENDER || uw.op == OP_ZERO) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_step_q <= STEP_W'(ACCENT_STEP_RST);
      nrm_step_q <= STEP_W'(NORMAL_STEP_RST);
      acc_len_q  <= LEN_W'(ACCENT_LEN_RST);
      nrm_len_q  <= LEN_W'(NORMAL_LEN_RST);
      acc_gain_q <= GAIN_W'(ACCENT_GAIN_RST);
      nrm_gain_q <= GAIN_W'(NORMAL_GAIN_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACCENT_STEP: acc_step_q <= cfg_data_i[STEP_W-1:0];
        REG_NORMAL_STEP: nrm_step_q <= cfg_data_i[STEP_W-1:0];
        REG_ACCENT_LEN:  acc_len_q  <= cfg_data_i[LEN_W-1:0];
        REG_NORMAL_LEN:  nrm_len_q  <= cfg_data_i[LEN_W-1:0];
        REG_ACCENT_GAIN: acc_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_NORMAL_GAIN: nrm_gain_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Voice state: load on beat, clear when stopped, advance after rendering
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      step_q   <= '0;
      gain_q   <= '0;
      remain_q <= '0;
      total_q  <= '0;
      run_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        run_q <= running_i;
      end
      if (uw.op == OP_LOAD) begin
        if (!run_q) begin
          phase_q  <= '0;
          step_q   <= '0;
          gain_q   <= '0;
          remain_q <= '0;
          total_q  <= '0;
        end else if (beat_q) begin
          phase_q  <= '0;
          step_q   <= accent_q ? acc_step_q : nrm_step_q;
          gain_q   <= accent_q ? acc_gain_q : nrm_gain_q;
          total_q  <= accent_q ? acc_len_q : nrm_len_q;
          remain_q <= accent_q ? acc_len_q : nrm_len_q;
        end
      end else if (uw.op == OP_RENDER) begin
        phase_q  <= phase_q + PHASE_W'(step_q);
        remain_q <= remain_q - LEN_W'(1);
      end
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      beat_q   <= beat_i;
      accent_q <= accent_i;
    end
    case (uw.op)
      OP_DIV_INIT: begin
        rem_q  <= {1'b0, remain_q};
        quot_q <= '0;
        dcnt_q <= DIV_CNT_W'(DIV_STEPS);
        smag_q <= QSINE[sk];
        neg_q  <= saddr[SINE_ADDR_BITS-1];
      end
      OP_DIV_STEP: begin
        rem_q  <= {rsel[QUOT_W-2:0], 1'b0};
        quot_q <= {quot_q[QUOT_W-2:0], ge};
        dcnt_q <= dcnt_q - DIV_CNT_W'(1);
      end
      OP_MUL_EE:  ee_q   <= mul_p[EE_W-1:0];
      OP_MUL_SG:  sg_q   <= mul_p[SG_W-1:0];
      OP_MUL_FIN: prod_q <= mul_p;
      OP_RENDER: begin
        sample_q <= neg_q ? $signed(SAMPLE_W'(0) - mag16) : $signed(mag16);
        active_q <= 1'b1;
      end
      OP_ZERO: begin
        sample_q <= '0;
        active_q <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
